### design/lse_pkg.sv
`default_nettype none
package lse_pkg;

   localparam int DATA_W        = 32;
   localparam int DEFAULT_DEPTH = 64;

   typedef logic [1:0] op_type;
   localparam op_type OP_PUSH = 2'd0;
   localparam op_type OP_POP  = 2'd1;
   localparam op_type OP_SWAP = 2'd2;
   localparam op_type OP_LIST = 2'd3;

   typedef logic [2:0] status_type;
   localparam status_type ST_OK         = 3'd0;
   localparam status_type ST_POP_EMPTY  = 3'd1;
   localparam status_type ST_SWAP_SHORT = 3'd2;
   localparam status_type ST_PUSH_FULL  = 3'd3;
   localparam status_type ST_LIST_EMPTY = 3'd4;

   typedef logic [1:0] sel_code_type;
   localparam sel_code_type SEL_HOLD  = 2'd0;
   localparam sel_code_type SEL_LEFT  = 2'd1;
   localparam sel_code_type SEL_RIGHT = 2'd2;
   localparam sel_code_type SEL_TOP   = 2'd3;

   typedef struct packed {
      sel_code_type sel;
   } cell_ctl_type;

   typedef logic signed [DATA_W-1:0] data_type;

endpackage
`default_nettype wire

### design/lse_cell.sv
`default_nettype none
module lse_cell (
   input  wire               clock,
   input  wire lse_pkg::cell_ctl_type ctl,
   input  wire lse_pkg::data_type left_value,
   input  wire lse_pkg::data_type right_value,
   input  wire lse_pkg::data_type top_value,
   output lse_pkg::data_type value
);

   lse_pkg::data_type value_ff;
   lse_pkg::data_type value_in;

   always_comb begin
      case (ctl.sel)
         lse_pkg::SEL_LEFT:  value_in = left_value;
         lse_pkg::SEL_RIGHT: value_in = right_value;
         lse_pkg::SEL_TOP:   value_in = top_value;
         default:            value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

### design/lifo_stack_engine.sv
`default_nettype none
// LIFO stack of signed 32-bit entries held in a row of STACK_DEPTH cells, cell 0 being the
// top. Push, pop and swap shift or exchange the cells in the cycle the request is accepted,
// and their single status result is registered for the next cycle, so these requests run at
// one per cycle while results are taken. A list request spends its accept cycle starting up,
// then emits one result per entry, top first, one per cycle while results are taken, by
// rotating the cells once around the filled part of the row; it takes no new request until
// the last entry is out, and the stack is back in order at its end.
// Failed operations return an error status and leave the stack untouched. Entries at or
// above the fill count hold no defined value and are never shown.
module lifo_stack_engine #(
   parameter int STACK_DEPTH = lse_pkg::DEFAULT_DEPTH
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire  [1:0]              req_type,
   input  wire  signed [31:0]      req_push_value,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output logic signed [31:0]      rsp_entry_value,
   output logic [2:0]              rsp_status,
   output logic                    rsp_last_of_run
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LIST = 1'b1;

   logic                state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lse_pkg::data_type   rsp_value_ff, rsp_value_in;
   lse_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   logic slot_free;
   logic accept;
   logic do_push, do_pop, do_swap, do_rotate;

   lse_pkg::data_type    cell_value [STACK_DEPTH];
   lse_pkg::cell_ctl_type cell_ctl  [STACK_DEPTH];

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      do_push       = 1'b0;
      do_pop        = 1'b0;
      do_swap       = 1'b0;
      do_rotate     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = lse_pkg::ST_OK;
               rsp_last_in   = 1'b1;
               unique case (req_type)
                  lse_pkg::OP_PUSH: begin
                     if (count_ff == CNT_W'(STACK_DEPTH)) begin
                        rsp_status_in = lse_pkg::ST_PUSH_FULL;
                     end else begin
                        do_push  = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  lse_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = lse_pkg::ST_POP_EMPTY;
                     end else begin
                        do_pop       = 1'b1;
                        count_in     = count_ff - CNT_W'(1);
                        rsp_value_in = cell_value[0];
                     end
                  end
                  lse_pkg::OP_SWAP: begin
                     if (count_ff < CNT_W'(2)) begin
                        rsp_status_in = lse_pkg::ST_SWAP_SHORT;
                     end else begin
                        do_swap = 1'b1;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_status_in = lse_pkg::ST_LIST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        remain_in    = count_ff;
                        state_in     = S_LIST;
                     end
                  end
               endcase
            end
         end
         default: begin
            if (slot_free) begin
               do_rotate     = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = cell_value[0];
               rsp_status_in = lse_pkg::ST_OK;
               rsp_last_in   = (remain_ff == CNT_W'(1));
               remain_in     = remain_ff - CNT_W'(1);
               if (remain_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         cell_ctl[i].sel = lse_pkg::SEL_HOLD;
         if (do_push) begin
            cell_ctl[i].sel = lse_pkg::SEL_LEFT;
         end else if (do_pop) begin
            cell_ctl[i].sel = lse_pkg::SEL_RIGHT;
         end else if (do_swap) begin
            if (i == 0) begin
               cell_ctl[i].sel = lse_pkg::SEL_RIGHT;
            end else if (i == 1) begin
               cell_ctl[i].sel = lse_pkg::SEL_LEFT;
            end
         end else if (do_rotate) begin
            if (CNT_W'(i + 1) == count_ff) begin
               cell_ctl[i].sel = lse_pkg::SEL_TOP;
            end else if (CNT_W'(i + 1) < count_ff) begin
               cell_ctl[i].sel = lse_pkg::SEL_RIGHT;
            end
         end
      end
   end

   for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
      lse_pkg::data_type left_value;
      lse_pkg::data_type right_value;
      if (g == 0) begin : g_first
         assign left_value = req_push_value;
      end else begin : g_mid
         assign left_value = cell_value[g-1];
      end
      if (g == STACK_DEPTH - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_inner
         assign right_value = cell_value[g+1];
      end
      lse_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[g]),
         .left_value  (left_value),
         .right_value (right_value),
         .top_value   (cell_value[0]),
         .value       (cell_value[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

typedef struct packed {
   lse_pkg::data_type   value;
   lse_pkg::status_type status;
   logic                last;
} stack_rsp_type;

class stack_scoreboard;
   int unsigned         depth;
   lse_pkg::data_type   shadow[];
   int unsigned         fill;
   stack_rsp_type       due_q[$];
   int                  errors;
   int                  accepted;
   int                  checked;
   int                  status_hits[5];

   function new(int unsigned stack_depth);
      depth    = stack_depth;
      shadow   = new[stack_depth];
      fill     = 0;
      errors   = 0;
      accepted = 0;
      checked  = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
   endfunction

   function void due(lse_pkg::data_type value, lse_pkg::status_type status, logic last);
      stack_rsp_type r;
      r.value  = value;
      r.status = status;
      r.last   = last;
      due_q.push_back(r);
   endfunction

   function void note_request(lse_pkg::op_type op, lse_pkg::data_type value);
      lse_pkg::data_type t;
      accepted++;
      case (op)
         lse_pkg::OP_PUSH: begin
            if (fill >= depth) begin
               due(0, lse_pkg::ST_PUSH_FULL, 1'b1);
            end else begin
               shadow[fill] = value;
               fill++;
               due(0, lse_pkg::ST_OK, 1'b1);
            end
         end
         lse_pkg::OP_POP: begin
            if (fill == 0) begin
               due(0, lse_pkg::ST_POP_EMPTY, 1'b1);
            end else begin
               fill--;
               due(shadow[fill], lse_pkg::ST_OK, 1'b1);
            end
         end
         lse_pkg::OP_SWAP: begin
            if (fill < 2) begin
               due(0, lse_pkg::ST_SWAP_SHORT, 1'b1);
            end else begin
               t = shadow[fill-1];
               shadow[fill-1] = shadow[fill-2];
               shadow[fill-2] = t;
               due(0, lse_pkg::ST_OK, 1'b1);
            end
         end
         default: begin
            if (fill == 0) begin
               due(0, lse_pkg::ST_LIST_EMPTY, 1'b1);
            end else begin
               for (int i = fill; i > 0; i--) due(shadow[i-1], lse_pkg::ST_OK, i == 1);
            end
         end
      endcase
   endfunction

   task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
   endtask

   task check_response(lse_pkg::data_type value, lse_pkg::status_type status, logic last);
      stack_rsp_type want;
      if (due_q.size() == 0) begin
         report_mismatch($sformatf("response with no request waiting: value %0d status %0d",
                                   value, status));
      end else begin
         want = due_q.pop_front();
         checked++;
         status_hits[want.status]++;
         if (value !== want.value)
            report_mismatch($sformatf("result %0d entry_value %0d, want %0d",
                                      checked, value, want.value));
         if (status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      checked, status, want.status));
         if (last !== want.last)
            report_mismatch($sformatf("result %0d last_of_run %0b, want %0b",
                                      checked, last, want.last));
      end
   endtask
endclass

module tb_top;

   localparam int DEPTH       = 64;
   localparam int TOTAL_ITEMS = 310;
   localparam int HOLD_CYCLES = 300;
   localparam int LIMIT       = 1000000;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic [1:0]          req_type       = lse_pkg::OP_PUSH;
   logic signed [31:0]  req_push_value = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic signed [31:0]  rsp_entry_value;
   logic [2:0]          rsp_status;
   logic                rsp_last_of_run;

   stack_scoreboard sb = new(DEPTH);

   int  cycles    = 0;
   int  sent      = 0;
   int  level     = 0;
   bit  tx_steady = 1'b0;
   bit  rx_steady = 1'b0;
   bit  hold_rsp  = 1'b0;

   lifo_stack_engine #(.STACK_DEPTH(DEPTH)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_entry_value (rsp_entry_value),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_type, req_push_value);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_entry_value, rsp_status, rsp_last_of_run);
      end
   end

   function automatic int draw_wait(bit steady);
      return steady ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic lse_pkg::data_type pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sh0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic lse_pkg::op_type choose_op(int push_w, int pop_w);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_w) return lse_pkg::OP_PUSH;
      if (r < push_w + pop_w) return lse_pkg::OP_POP;
      return ($urandom_range(0, 2) == 0) ? lse_pkg::OP_LIST : lse_pkg::OP_SWAP;
   endfunction

   task send_request(lse_pkg::op_type op, lse_pkg::data_type value);
      int gap;
      gap = draw_wait(tx_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= op;
      req_push_value <= value;
      do @(posedge clock); while (!req_ready);
      sent++;
      if (op == lse_pkg::OP_PUSH && level < DEPTH) level++;
      if (op == lse_pkg::OP_POP && level > 0) level--;
   endtask

   task send_random(lse_pkg::op_type op);
      send_request(op, pick_value());
   endtask

   task fill_phase();
      while (level < DEPTH) send_random(choose_op(85, 5));
      repeat ($urandom_range(1, 3)) send_random(lse_pkg::OP_PUSH);
      send_random(lse_pkg::OP_LIST);
   endtask

   task drain_phase();
      while (level > 0) send_random(choose_op(5, 85));
      repeat ($urandom_range(1, 2)) send_random(lse_pkg::OP_POP);
      send_random(lse_pkg::OP_SWAP);
      send_random(lse_pkg::OP_LIST);
   endtask

   task mixed_phase();
      repeat ($urandom_range(20, 40)) send_random(choose_op(40, 30));
   endtask

   initial begin
      int gap;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = draw_wait(rx_steady);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   initial begin
      int goal;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_request(lse_pkg::OP_LIST, 32'sh0);
      send_request(lse_pkg::OP_POP, 32'sh7FFF_FFFF);
      send_request(lse_pkg::OP_SWAP, -32'sd1);
      send_request(lse_pkg::OP_PUSH, 32'sh7FFF_FFFF);
      send_request(lse_pkg::OP_SWAP, 32'sh0);
      send_request(lse_pkg::OP_LIST, 32'sh8000_0000);
      send_request(lse_pkg::OP_PUSH, 32'sh8000_0000);
      send_request(lse_pkg::OP_PUSH, -32'sd1);
      send_request(lse_pkg::OP_PUSH, 32'sh0);
      send_request(lse_pkg::OP_SWAP, 32'sh1234_5678);
      send_request(lse_pkg::OP_LIST, 32'sh0);
      send_request(lse_pkg::OP_POP, 32'sh0);
      send_request(lse_pkg::OP_POP, 32'sh0);
      send_request(lse_pkg::OP_PUSH, 32'sh5555_5555);
      send_request(lse_pkg::OP_PUSH, 32'shAAAA_AAAA);
      send_request(lse_pkg::OP_SWAP, 32'sh0);
      send_request(lse_pkg::OP_LIST, 32'sh0);
      repeat (4) send_request(lse_pkg::OP_POP, 32'sh0);
      send_request(lse_pkg::OP_POP, 32'sh0);
      send_request(lse_pkg::OP_SWAP, 32'sh0);
      send_request(lse_pkg::OP_LIST, 32'sh0);

      goal = TOTAL_ITEMS;
      tx_steady = 1'b1;
      hold_rsp  = 1'b1;
      fill_phase();
      tx_steady = 1'b0;
      drain_phase();
      while (sent < goal) begin
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 3))
            0: fill_phase();
            1: drain_phase();
            default: mixed_phase();
         endcase
      end
      req_valid <= 1'b0;

      while (sb.accepted != sent || sb.due_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d requests and %0d results in %0d cycles.",
               sent, sb.checked, cycles);
      $display("Error results: pop empty %0d, swap short %0d, push full %0d, list empty %0d.",
               sb.status_hits[lse_pkg::ST_POP_EMPTY], sb.status_hits[lse_pkg::ST_SWAP_SHORT],
               sb.status_hits[lse_pkg::ST_PUSH_FULL], sb.status_hits[lse_pkg::ST_LIST_EMPTY]);
      if (sb.errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule

### filelist.f
design/lse_pkg.sv
design/lse_cell.sv
design/lifo_stack_engine.sv
tb/sv/tb_top.sv
